FILE: rtl/ffr_pkg.sv
// Package for the fill-first token router: word types, operation and status codes,
// and the constants of the budget arithmetic.
// No dependencies; every other file of the block imports it.
package ffr_pkg;

   // Widths fixed by the word formats.
   localparam int ACTION_W  = 2;
   localparam int DEST_W    = 4;
   localparam int SEQ_W     = 64;
   localparam int STATUS_W  = 3;
   localparam int USAGE_W   = 7;
   localparam int TOKEN_W   = 7;
   localparam int USED_W    = 16;
   localparam int PROD_W    = 14;
   localparam int BUDGET_W  = 7;

   // Largest destination count that the destination field can address.
   localparam int DEST_SPAN = 2 ** DEST_W;

   // Reset value of the usage percentage register.
   localparam logic [USAGE_W-1:0] USAGE_RESET = 7'd50;

   // Ceiling division by 100: add 99, then multiply by 2^20/100 rounded up and shift.
   localparam logic [PROD_W-1:0]   ROUND_UP     = 14'd99;
   localparam logic [2*PROD_W-1:0] RECIP_100    = 28'd10486;
   localparam int                  RECIP_SHIFT  = 20;

   // The used counter stops at its top value.
   localparam logic [USED_W-1:0] USED_MAX = 16'hFFFF;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_TAKEN   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ROUTE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

   // Operations, encoded as the action field encodes them.
   typedef enum logic [ACTION_W-1:0] {
      OP_ADD   = 2'd0,
      OP_TABLE = 2'd1,
      OP_ROUTE = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Execution unit states.
   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_BUDGET = 2'd1,
      BK_EMIT   = 2'd2
   } back_state_type;

   // Request word.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [DEST_W-1:0]   dest_in;
      logic [SEQ_W-1:0]    seq_in;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEQ_W-1:0]    seq_out;
      logic [DEST_W-1:0]   dest_out;
      logic                last;
   } rsp_type;

   // Decoded command held in the queue between front and back.
   typedef struct packed {
      op_type              op;
      logic                dest_bad;
      logic [DEST_W-1:0]   dest;
      logic [SEQ_W-1:0]    seq;
   } cmd_type;

   // Queue status seen by the two sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/fill_first_token_router_top.sv
// Top level of the fill-first token router: usage register, front, queue and back.
// Depends on ffr_pkg, ffr_front, ffr_queue and ffr_back.
//
//   Channel    Ports                       Transfer
//   request    start, busy, req_data       taken when start is high and busy is low
//   response   rsp_strobe, rsp_data        one cycle per word, cannot be held off
//   register   csr_we, csr_wdata           usage percent, written when csr_we is high
//
// An add, route or clear word is held in the queue, then answered through the back part's
// response register. A table word while no tokens are held gets a single none word; else
// the idle and budget states compute the budget, then the emit state gives one entry per
// cycle, at most TOKEN_CAPACITY entries, and the back part takes no new word until the last.
// The back part runs one word at a time; the two-entry queue takes up to two more
// words, and busy is high while it is full. Synchronous reset clears all tokens,
// counters and the queue, sets the usage percent to 50, and holds busy high.
module fill_first_token_router_top
   import ffr_pkg::*;
#(
   parameter int NUM_DESTS      = 16,
   parameter int TOKEN_CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [USAGE_W-1:0] csr_wdata
);

   logic [USAGE_W-1:0] usage_ff;
   logic               push;
   logic               pop;
   cmd_type            push_cmd;
   cmd_type            head_cmd;
   queue_status_type   q_status;

   // Usage percent register.
   always_ff @(posedge clock) begin
      if (reset) begin
         usage_ff <= USAGE_RESET;
      end else if (csr_we) begin
         usage_ff <= csr_wdata;
      end
   end

   ffr_front #(
      .NUM_DESTS (NUM_DESTS)
   ) u_front (
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .q_status (q_status),
      .busy     (busy),
      .push     (push),
      .cmd      (push_cmd)
   );

   ffr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   ffr_back #(
      .NUM_DESTS      (NUM_DESTS),
      .TOKEN_CAPACITY (TOKEN_CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .usage      (usage_ff),
      .q_valid    (~q_status.empty),
      .q_cmd      (head_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: rtl/ffr_front.sv
// Front part of the token router: accepts request words and decodes them into commands.
// Depends on ffr_pkg; pushes into ffr_queue.
module ffr_front
   import ffr_pkg::*;
#(
   parameter int NUM_DESTS = 16
) (
   input  logic             reset,
   input  logic             start,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             busy,
   output logic             push,
   output cmd_type          cmd
);

   // No word is taken during reset or while the queue has no room.
   assign busy = reset | q_status.full;
   assign push = start & ~busy;

   // Decode the action and check the destination against the configured count.
   always_comb begin
      cmd.dest     = req_data.dest_in;
      cmd.seq      = req_data.seq_in;
      cmd.dest_bad = 32'(req_data.dest_in) >= 32'(NUM_DESTS);
      cmd.op       = op_type'(req_data.action);
   end

endmodule

FILE: rtl/ffr_queue.sv
// Two-entry command queue between the front and the back of the token router.
// Depends on ffr_pkg.
module ffr_queue
   import ffr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign status.full  = count_ff == 2'd2;
   assign status.empty = count_ff == 2'd0;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/ffr_back.sv
// Back part of the token router: token counters per destination, budget arithmetic,
// and the sequencer that carries out each command and drives the response word.
// Depends on ffr_pkg; pops commands from ffr_queue.
module ffr_back
   import ffr_pkg::*;
#(
   parameter int NUM_DESTS      = 16,
   parameter int TOKEN_CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [USAGE_W-1:0]  usage,
   input  logic                q_valid,
   input  cmd_type             q_cmd,
   output logic                pop,
   output logic                rsp_strobe,
   output rsp_type             rsp_data
);

   // Destinations beyond the reach of the destination field never hold tokens.
   localparam int NUM_CELLS = (NUM_DESTS < DEST_SPAN) ? NUM_DESTS : DEST_SPAN;

   back_state_type      state_ff;
   back_state_type      state_in;
   logic [TOKEN_W-1:0]  tok_cnt_ff [NUM_CELLS];
   logic [TOKEN_W-1:0]  held_ff;
   logic [TOKEN_W-1:0]  held_in;
   logic [SEQ_W-1:0]    next_seq_ff;
   logic [SEQ_W-1:0]    next_seq_in;
   logic [USED_W-1:0]   used_ff;
   logic [USED_W-1:0]   used_in;
   logic [USED_W-1:0]   used_bump;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [BUDGET_W-1:0] budget_ff;
   logic [BUDGET_W-1:0] budget_in;
   logic [2*PROD_W-1:0] scaled;
   logic                rsp_strobe_ff;
   logic                rsp_strobe_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   logic                inc;
   logic                dec;
   logic [DEST_W-1:0]   low_idx;
   logic                entry_last;

   // Lowest destination that holds a token.
   always_comb begin
      low_idx = '0;
      for (int i = NUM_CELLS - 1; i >= 0; i--) begin
         if (tok_cnt_ff[i] != '0) begin
            low_idx = DEST_W'(i);
         end
      end
   end

   // Saturating increment of the used counter.
   assign used_bump = (used_ff == USED_MAX) ? used_ff : used_ff + 16'd1;

   // Budget = (held * percent + 99) / 100, by reciprocal multiplication.
   assign scaled = 28'(prod_ff) * RECIP_100;

   // A table entry is the last one when the budget is met or the store runs dry.
   assign entry_last = (used_bump >= 16'(budget_ff)) || (held_ff == 7'd1);

   // Sequencer: next state, bookkeeping and response word.
   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      next_seq_in   = next_seq_ff;
      used_in       = used_ff;
      prod_in       = prod_ff;
      budget_in     = budget_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      pop           = 1'b0;
      inc           = 1'b0;
      dec           = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               unique case (q_cmd.op)
                  OP_ADD: begin
                     rsp_strobe_in        = 1'b1;
                     rsp_data_in.dest_out = q_cmd.dest;
                     rsp_data_in.last     = 1'b1;
                     if (q_cmd.dest_bad || held_ff >= TOKEN_W'(TOKEN_CAPACITY)) begin
                        rsp_data_in.status = ST_DROPPED;
                     end else begin
                        inc                = 1'b1;
                        held_in            = held_ff + 7'd1;
                        rsp_data_in.status = ST_TAKEN;
                     end
                  end
                  OP_TABLE: begin
                     if (held_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = ST_NONE;
                        rsp_data_in.last   = 1'b1;
                     end else begin
                        prod_in  = 14'(held_ff) * 14'(usage) + ROUND_UP;
                        state_in = BK_BUDGET;
                     end
                  end
                  OP_ROUTE: begin
                     rsp_strobe_in    = 1'b1;
                     rsp_data_in.last = 1'b1;
                     if (held_ff == '0) begin
                        rsp_data_in.status = ST_NONE;
                     end else begin
                        dec                  = 1'b1;
                        held_in              = held_ff - 7'd1;
                        used_in              = used_bump;
                        rsp_data_in.status   = ST_ROUTE;
                        rsp_data_in.seq_out  = q_cmd.seq;
                        rsp_data_in.dest_out = low_idx;
                     end
                  end
                  OP_CLEAR: begin
                     used_in            = '0;
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = ST_CLEARED;
                     rsp_data_in.last   = 1'b1;
                  end
                  default: begin
                     state_in = BK_IDLE;
                  end
               endcase
            end
         end
         BK_BUDGET: begin
            budget_in = BUDGET_W'(scaled >> RECIP_SHIFT);
            state_in  = BK_EMIT;
         end
         BK_EMIT: begin
            // One table entry per cycle from the lowest destination.
            dec                  = 1'b1;
            held_in              = held_ff - 7'd1;
            used_in              = used_bump;
            next_seq_in          = next_seq_ff + 64'd1;
            rsp_strobe_in        = 1'b1;
            rsp_data_in.status   = ST_ROUTE;
            rsp_data_in.seq_out  = next_seq_ff;
            rsp_data_in.dest_out = low_idx;
            rsp_data_in.last     = entry_last;
            if (entry_last) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         held_ff       <= '0;
         next_seq_ff   <= '0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         next_seq_ff   <= next_seq_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Arithmetic and response payload registers.
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      budget_ff   <= budget_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Token counters, one per destination; an add and a take never meet in one cycle.
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
         if (reset) begin
            tok_cnt_ff[i] <= '0;
         end else if (inc && q_cmd.dest == DEST_W'(i)) begin
            tok_cnt_ff[i] <= tok_cnt_ff[i] + 7'd1;
         end else if (dec && low_idx == DEST_W'(i)) begin
            tok_cnt_ff[i] <= tok_cnt_ff[i] - 7'd1;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

FILE: rtl/ffr_checker.sv
// Port-level checks for the fill-first token router, bound to the top level.
// Depends on ffr_pkg and fill_first_token_router_top.
module ffr_checker
   import ffr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // No word is taken while reset is applied.
   a_busy_in_reset: assert property (@(posedge clock) reset |-> busy)
      else $error("busy low during reset");

   // Reset leaves no response word on the port.
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("response word right after reset");

   // Only table entries may be followed by more words of the same request.
   a_single_word_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_ROUTE) |-> rsp_data.last)
      else $error("non-route word without last");

   // Table entries follow each other in back-to-back cycles with rising sequence numbers.
   a_table_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_ROUTE && !rsp_data.last) |=>
      (rsp_strobe && rsp_data.status == ST_ROUTE &&
       rsp_data.seq_out == $past(rsp_data.seq_out) + 64'd1))
      else $error("table entries broken");

endmodule

bind fill_first_token_router_top ffr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
